[sv/rfdp_pkg.sv]
// rfdp_pkg: shared types, codes and constants of the record format
// descriptor parser. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rfdp_pkg;

  localparam int unsigned DEF_POINTER_BYTES = 8;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned SIZE_W    = 4;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 112;

  // input op
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  // result kind
  localparam logic KIND_ITEM    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK              = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_CHAR        = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DANGLING_REPEAT = 2'd2;

  // characters with a meaning of their own
  localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CH_W-1:0] CH_AT     = 8'h40;
  localparam logic [CH_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [CH_W-1:0] CH_LT     = 8'h3C;
  localparam logic [CH_W-1:0] CH_GT     = 8'h3E;
  localparam logic [CH_W-1:0] CH_BANG   = 8'h21;
  localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CH_W-1:0] CH_PAD    = 8'h78; // 'x'
  localparam logic [CH_W-1:0] CH_STR    = 8'h73; // 's'
  localparam logic [CH_W-1:0] CH_PSTR   = 8'h70; // 'p'

  typedef struct packed {
    logic            op;
    logic [CH_W-1:0] ch;
  } in_beat_t;

  typedef struct packed {
    logic                kind;
    logic [CH_W-1:0]     code;
    logic [COUNT_W-1:0]  item_count;
    logic [SIZE_W-1:0]   elem_size;
    logic [COUNT_W-1:0]  total_bytes;
    logic [COUNT_W-1:0]  arg_total;
    logic                little_order;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

`default_nettype wire

[sv/record_format_descriptor_parser_top.sv]
// record_format_descriptor_parser_top: stream wrapper around input register,
// parse step and result register. Uses rfdp_pkg, rfdp_in_reg, rfdp_parse, rfdp_out_reg.
`timescale 1ns / 1ps
`default_nettype none

// Takes a struct-style format string one character per beat and returns one
// descriptor beat per type code plus a summary beat at the end marker. The
// parser state register is updated once per accepted beat, whitespace
// included, so the block sustains one beat per clock while no result is
// stalled. A result passes the input register, then the result register,
// on its way to the master side. A stalled result stalls only characters
// that produce a result; whitespace, digits and prefixes keep flowing into
// the state.
module record_format_descriptor_parser_top #(
  parameter int unsigned POINTER_BYTES = rfdp_pkg::DEF_POINTER_BYTES
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output      logic                             s_axis_tready_o,
  input  wire logic [rfdp_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,  // [7:0] ch
  input  wire logic                             s_axis_tuser_i,  // [0] op
  output      logic                             m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // [7:0] code, [39:8] item_count, [43:40] elem_size, [75:44] total_bytes,
  // [107:76] arg_total, [108] little_order, [110:109] status, [111] zero
  output      logic [rfdp_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output      logic                             m_axis_tuser_o   // [0] kind
);

  rfdp_pkg::in_beat_t s_beat, in_beat;
  rfdp_pkg::result_t  res, m_res;
  logic               in_valid, adv, push, out_busy;

  assign s_beat.op = s_axis_tuser_i;
  assign s_beat.ch = s_axis_tdata_i;

  rfdp_in_reg u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_beat_i  (s_beat),
    .valid_o   (in_valid),
    .beat_o    (in_beat),
    .adv_i     (adv)
  );

  rfdp_parse #(
    .PointerBytes (POINTER_BYTES)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid),
    .beat_i     (in_beat),
    .out_busy_i (out_busy),
    .adv_o      (adv),
    .push_o     (push),
    .res_o      (res)
  );

  rfdp_out_reg u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .res_i     (res),
    .busy_o    (out_busy),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_res_o   (m_res)
  );

  assign m_axis_tuser_o = m_res.kind;
  assign m_axis_tdata_o = {1'b0, m_res.status, m_res.little_order, m_res.arg_total,
                           m_res.total_bytes, m_res.elem_size, m_res.item_count,
                           m_res.code};

endmodule

`default_nettype wire

[sv/rfdp_in_reg.sv]
// rfdp_in_reg: input register stage of the parser.
// Uses rfdp_pkg::in_beat_t.
`timescale 1ns / 1ps
`default_nettype none

module rfdp_in_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_valid_i,
  output      logic             s_ready_o,
  input  wire rfdp_pkg::in_beat_t s_beat_i,
  output      logic             valid_o,
  output      rfdp_pkg::in_beat_t beat_o,
  input  wire logic             adv_i
);

  logic               valid_q, valid_d;
  rfdp_pkg::in_beat_t beat_q;

  // slot is free when empty or drained this cycle
  assign s_ready_o = !valid_q || adv_i;

  always_comb begin
    valid_d = valid_q;
    if (s_ready_o) begin
      valid_d = s_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      beat_q <= s_beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

`default_nettype wire

[sv/rfdp_parse.sv]
// rfdp_parse: parser state and the per-character decode and update step.
// Uses rfdp_pkg types, codes and character constants.
`timescale 1ns / 1ps
`default_nettype none

module rfdp_parse #(
  parameter int unsigned PointerBytes = rfdp_pkg::DEF_POINTER_BYTES
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire rfdp_pkg::in_beat_t beat_i,
  input  wire logic               out_busy_i,
  output      logic               adv_o,
  output      logic               push_o,
  output      rfdp_pkg::result_t  res_o
);

  localparam int unsigned CW = rfdp_pkg::COUNT_W;
  localparam int unsigned SW = rfdp_pkg::SIZE_W;

  function automatic logic [SW-1:0] code_size(input logic [rfdp_pkg::CH_W-1:0] c);
    logic [SW-1:0] s;
    begin
      case (c)
        rfdp_pkg::CH_PAD, 8'h63, 8'h62, 8'h42, 8'h3F: s = 4'd1; // x c b B ?
        8'h68, 8'h48:                             s = 4'd2; // h H
        8'h69, 8'h49, 8'h6C, 8'h4C, 8'h66:        s = 4'd4; // i I l L f
        8'h71, 8'h51, 8'h64:                      s = 4'd8; // q Q d
        8'h50, 8'h6E, 8'h4E:                      s = SW'(PointerBytes); // P n N
        default:                                  s = 4'd0;
      endcase
      return s;
    end
  endfunction

  logic                          pend;
  logic [CW-1:0]                 repeat_q, repeat_d;
  logic                          prefix_q, prefix_d;
  logic                          seen_q, seen_d;
  logic                          little_q, little_d;
  logic [CW-1:0]                 bytes_q, bytes_d;
  logic [CW-1:0]                 args_q, args_d;
  logic [rfdp_pkg::STATUS_W-1:0] err_q, err_d;

  logic [rfdp_pkg::CH_W-1:0] ch;
  logic                      is_ws, is_prefix, is_digit, is_str;
  logic [CW-1:0]             cnt;
  logic [SW-1:0]             size;
  logic [CW+SW-1:0]          prod;
  logic                      has_res;

  assign pend = (repeat_q != '0);

  assign ch        = beat_i.ch;
  assign is_ws     = (ch == rfdp_pkg::CH_SPACE) ||
                     ((ch >= rfdp_pkg::CH_TAB) && (ch <= rfdp_pkg::CH_CR));
  assign is_prefix = (ch == rfdp_pkg::CH_AT) || (ch == rfdp_pkg::CH_EQ) ||
                     (ch == rfdp_pkg::CH_LT) || (ch == rfdp_pkg::CH_GT) ||
                     (ch == rfdp_pkg::CH_BANG);
  assign is_digit  = (ch >= rfdp_pkg::CH_ZERO) && (ch <= rfdp_pkg::CH_NINE);
  assign is_str    = (ch == rfdp_pkg::CH_STR) || (ch == rfdp_pkg::CH_PSTR);
  assign cnt       = pend ? repeat_q : CW'(1);
  assign size      = is_str ? SW'(1) : code_size(ch);
  assign prod      = cnt * size;

  always_comb begin
    repeat_d = repeat_q;
    prefix_d = prefix_q;
    seen_d   = seen_q;
    little_d = little_q;
    bytes_d  = bytes_q;
    args_d   = args_q;
    err_d    = err_q;
    has_res  = 1'b0;

    res_o.kind         = rfdp_pkg::KIND_ITEM;
    res_o.code         = ch;
    res_o.item_count   = cnt;
    res_o.elem_size    = size;
    res_o.total_bytes  = bytes_q;
    res_o.arg_total    = args_q;
    res_o.little_order = little_q;
    res_o.status       = rfdp_pkg::ST_OK;

    if (beat_i.op == rfdp_pkg::OP_END) begin
      has_res            = 1'b1;
      res_o.kind         = rfdp_pkg::KIND_SUMMARY;
      res_o.code         = '0;
      res_o.item_count   = '0;
      res_o.elem_size    = '0;
      if (err_q != rfdp_pkg::ST_OK) begin
        res_o.status = err_q;
      end else if (pend) begin
        res_o.status = rfdp_pkg::ST_DANGLING_REPEAT;
      end
      // back to the reset state
      repeat_d = '0;
      prefix_d = 1'b0;
      seen_d   = 1'b0;
      little_d = 1'b1;
      bytes_d  = '0;
      args_d   = '0;
      err_d    = rfdp_pkg::ST_OK;
    end else if (err_q != rfdp_pkg::ST_OK || is_ws) begin
      // sticky error or whitespace: nothing to do
    end else if (is_prefix) begin
      if (prefix_q || seen_q || pend) begin
        err_d = rfdp_pkg::ST_BAD_CHAR;
      end else begin
        prefix_d = 1'b1;
        little_d = !((ch == rfdp_pkg::CH_GT) || (ch == rfdp_pkg::CH_BANG));
      end
    end else if (is_digit) begin
      // x*10 = x<<3 + x<<1; digit is the low nibble of the ASCII code
      repeat_d = {repeat_q[CW-4:0], 3'b000} + {repeat_q[CW-2:0], 1'b0} +
                 CW'(ch[3:0]);
    end else begin
      repeat_d = '0;
      if (size == '0) begin
        err_d = rfdp_pkg::ST_BAD_CHAR;
      end else begin
        has_res = 1'b1;
        seen_d  = 1'b1;
        if (is_str) begin
          bytes_d = bytes_q + cnt;
          args_d  = args_q + CW'(1);
        end else begin
          bytes_d = bytes_q + prod[CW-1:0];
          if (ch != rfdp_pkg::CH_PAD) begin
            args_d = args_q + cnt;
          end
        end
        res_o.total_bytes = bytes_d;
        res_o.arg_total   = args_d;
      end
    end
  end

  assign adv_o  = valid_i && !(has_res && out_busy_i);
  assign push_o = adv_o && has_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_q <= '0;
      prefix_q <= 1'b0;
      seen_q   <= 1'b0;
      little_q <= 1'b1;
      bytes_q  <= '0;
      args_q   <= '0;
      err_q    <= rfdp_pkg::ST_OK;
    end else if (adv_o) begin
      repeat_q <= repeat_d;
      prefix_q <= prefix_d;
      seen_q   <= seen_d;
      little_q <= little_d;
      bytes_q  <= bytes_d;
      args_q   <= args_d;
      err_q    <= err_d;
    end
  end

endmodule

`default_nettype wire

[sv/rfdp_out_reg.sv]
// rfdp_out_reg: result register holding one beat for the master side.
// Uses rfdp_pkg::result_t.
`timescale 1ns / 1ps
`default_nettype none

module rfdp_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire rfdp_pkg::result_t res_i,
  output      logic              busy_o,
  output      logic              m_valid_o,
  input  wire logic              m_ready_i,
  output      rfdp_pkg::result_t m_res_o
);

  logic              valid_q, valid_d;
  rfdp_pkg::result_t res_q;

  // cannot take a new result while the held one is stalled
  assign busy_o = valid_q && !m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_res_o   = res_q;

endmodule

`default_nettype wire

[sv/rfdp_checker.sv]
// rfdp_checker: port-level assertions for the parser top, plus its bind.
// Uses rfdp_pkg codes.
`timescale 1ns / 1ps
`default_nettype none

module rfdp_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid_i,
  input wire logic                             s_axis_tready_o,
  input wire logic [rfdp_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input wire logic                             s_axis_tuser_i,
  input wire logic                             m_axis_tvalid_o,
  input wire logic                             m_axis_tready_i,
  input wire logic [rfdp_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input wire logic                             m_axis_tuser_o
);

  logic in_beat;
  assign in_beat = s_axis_tvalid_i && s_axis_tready_o && (s_axis_tdata_i != '0 ||
                   s_axis_tuser_i == rfdp_pkg::OP_END || s_axis_tuser_i == rfdp_pkg::OP_CHAR);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  // descriptors always report ok and carry a real element size
  a_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == rfdp_pkg::KIND_ITEM |->
      m_axis_tdata_o[110:109] == rfdp_pkg::ST_OK &&
      m_axis_tdata_o[43:40] != 4'd0 && m_axis_tdata_o[43:40] <= 4'd8)
    else $error("bad descriptor fields");

  // summary carries no code, count or size, and a defined status code
  a_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == rfdp_pkg::KIND_SUMMARY |->
      m_axis_tdata_o[43:0] == 44'd0 && m_axis_tdata_o[110:109] != 2'd3)
    else $error("bad summary fields");

  // a rising result beat follows an accepted input beat, an input stall or an earlier result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(in_beat, 2) || $past(in_beat, 3) ||
      $past(s_axis_tready_o == 1'b0) || $past(m_axis_tvalid_o, 2))
    else $error("result beat without input");

endmodule

bind record_format_descriptor_parser_top rfdp_checker u_rfdp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
